>>> hw/rtl/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg
// Types, character codes and the hex digit lookup for the quoted-printable
// encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  // One raw message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } raw_beat_t;

  // One encoded output character
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } enc_beat_t;

  // Character codes
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;

  // Printable range passed through unescaped, except '='
  localparam logic [7:0] PRINT_LO = 8'd33;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam logic [6:0] LIMIT_RESET = 7'd72;

  // Longest run of output characters for one input byte
  localparam int unsigned RUN_MAX = 8;
  localparam int unsigned RUN_IDX_W = $clog2(RUN_MAX);
  localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);

  // Upper-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

>>> hw/rtl/quoted_printable_encoder_core.sv
// ----------------------------------------------------------------------------
// quoted_printable_encoder_core
// Quoted-printable encoder: one raw byte in, a run of one to eight encoded
// characters out, one character per beat.
// ----------------------------------------------------------------------------
// The first character of a run is on the output in the cycle after the byte is
// taken. A byte's run goes out one character per beat; the next byte is taken
// in the cycle the last character of the current run goes out, so the output
// port sets the rate. Reset clears line width, last character, message flag
// and the run count, and sets the line limit to 72.
module quoted_printable_encoder_core (
  input  logic               clk,
  input  logic               rst,
  // raw byte channel
  input  logic               raw_valid,
  output logic               raw_stall,
  input  qpe_pkg::raw_beat_t raw_beat,
  // encoded character channel
  output logic               enc_valid,
  input  logic               enc_stall,
  output qpe_pkg::enc_beat_t enc_beat,
  // line limit register
  input  logic               limit_we,
  input  logic [6:0]         limit_data
);

  // Configuration and encoder state
  logic [6:0] line_limit;
  logic [6:0] line_width;
  logic [7:0] previous_out;
  logic       emitted_any;

  // Run buffer: character 0 is on the output
  logic [7:0]                      run_buf [qpe_pkg::RUN_MAX];
  logic [qpe_pkg::RUN_CNT_W-1:0]   run_cnt;

  // Encode results
  logic [7:0]                      run_next [qpe_pkg::RUN_MAX];
  logic [qpe_pkg::RUN_CNT_W-1:0]   run_len;
  logic [6:0]                      line_width_next;
  logic [7:0]                      previous_out_next;
  logic [7:0]                      c;
  logic                            is_lf;
  logic                            is_ws;
  logic                            esc;
  logic [7:0]                      width_sum;
  logic                            soft_break;

  logic accept;
  logic take;

  // Handshake
  assign enc_valid = (run_cnt != '0);
  assign take      = enc_valid && !enc_stall;
  assign raw_stall = enc_valid && !((run_cnt == qpe_pkg::RUN_CNT_W'(1)) && !enc_stall);
  assign accept    = raw_valid && !raw_stall;

  assign enc_beat.out_byte    = run_buf[0];
  assign enc_beat.last_of_run = (run_cnt == qpe_pkg::RUN_CNT_W'(1));

  // Classification and width
  assign c     = raw_beat.data_byte;
  assign is_lf = (c == qpe_pkg::CHAR_LF);
  assign is_ws = (c == qpe_pkg::CHAR_TAB) || (c == qpe_pkg::CHAR_SPACE)
              || (c == qpe_pkg::CHAR_DOT);
  assign esc   = is_ws ? (line_width == '0)
               : ((c == qpe_pkg::CHAR_EQ) || (c < qpe_pkg::PRINT_LO)
                  || (c > qpe_pkg::PRINT_HI));

  assign width_sum  = is_lf ? 8'd0 : ({1'b0, line_width} + (esc ? 8'd3 : 8'd1));
  assign soft_break = (width_sum != 8'd0) && (width_sum >= {1'b0, line_limit});

  // Build the run of output characters
  always_comb begin
    for (int i = 0; i < qpe_pkg::RUN_MAX; i++) begin
      run_next[i] = 8'h00;
    end
    run_len = '0;

    if (is_lf) begin
      // soft break before a hard break after trailing whitespace or a line break
      if (emitted_any && (previous_out <= qpe_pkg::CHAR_SPACE)) begin
        run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_EQ;
        run_len = run_len + 1'b1;
        run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_CR;
        run_len = run_len + 1'b1;
        run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_LF;
        run_len = run_len + 1'b1;
      end
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_CR;
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_LF;
      run_len = run_len + 1'b1;
    end else if (esc) begin
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_EQ;
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::hex_digit(c[7:4]);
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::hex_digit(c[3:0]);
      run_len = run_len + 1'b1;
    end else begin
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = c;
      run_len = run_len + 1'b1;
    end

    // soft break at the line limit
    if (soft_break) begin
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_EQ;
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_CR;
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_LF;
      run_len = run_len + 1'b1;
    end

    // message end
    if (raw_beat.end_of_message) begin
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_CR;
      run_len = run_len + 1'b1;
      run_next[run_len[qpe_pkg::RUN_IDX_W-1:0]] = qpe_pkg::CHAR_LF;
      run_len = run_len + 1'b1;
    end
  end

  // Next state after this byte
  always_comb begin
    if (raw_beat.end_of_message) begin
      line_width_next   = '0;
      previous_out_next = 8'h00;
    end else begin
      line_width_next = soft_break ? 7'd0 : width_sum[6:0];
      if (soft_break || is_lf) begin
        previous_out_next = qpe_pkg::CHAR_LF;
      end else if (esc) begin
        previous_out_next = qpe_pkg::hex_digit(c[3:0]);
      end else begin
        previous_out_next = c;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit   <= qpe_pkg::LIMIT_RESET;
      line_width   <= '0;
      previous_out <= 8'h00;
      emitted_any  <= 1'b0;
      run_cnt      <= '0;
    end else begin
      if (limit_we) begin
        line_limit <= limit_data;
      end
      if (accept) begin
        line_width   <= line_width_next;
        previous_out <= previous_out_next;
        emitted_any  <= !raw_beat.end_of_message;
        run_cnt      <= run_len;
      end else if (take) begin
        run_cnt <= run_cnt - 1'b1;
      end
    end
  end

  // Run buffer: load on accept, shift on each beat out
  always_ff @(posedge clk) begin
    if (accept) begin
      run_buf <= run_next;
    end else if (take) begin
      for (int i = 0; i < qpe_pkg::RUN_MAX - 1; i++) begin
        run_buf[i] <= run_buf[i+1];
      end
      run_buf[qpe_pkg::RUN_MAX-1] <= 8'h00;
    end
  end

endmodule
